/* sv/trz_pkg.sv */
// Shared types, widths and codes of the triangle rasterizer with depth store.
package trz_pkg;

	localparam int MAX_WIDTH_DEF  = 256;
	localparam int MAX_HEIGHT_DEF = 256;

	localparam int CMD_W      = 2;
	localparam int VTX_W      = 13;
	localparam int VDEPTH_W   = 24;
	localparam int COLOR_W    = 32;
	localparam int ZBUF_W     = 8;
	localparam int COUNT_W    = 17;
	localparam int CFG_W      = 9;
	localparam int CFG_IDX_W  = 1;
	// Frame coordinates are 12 bits wide, enough for 4096 pixels on a side.
	localparam int CRD_W      = 12;
	// Edge areas and the depth sum, with headroom for the full vertex range.
	localparam int E_W        = 32;
	localparam int S_W        = 56;
	localparam int PROD_W     = 64;

	localparam logic [CMD_W-1:0] CMD_DRAW  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd1;
	localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic [1:0] JOB_NOP   = 2'd0;
	localparam logic [1:0] JOB_DRAW  = 2'd1;
	localparam logic [1:0] JOB_CLEAR = 2'd2;
	localparam logic [1:0] JOB_READ  = 2'd3;

	typedef struct packed {
		logic [1:0]                   kind;
		logic signed [VTX_W-1:0]      ax;
		logic signed [VTX_W-1:0]      ay;
		logic signed [VTX_W-1:0]      bx;
		logic signed [VTX_W-1:0]      by;
		logic signed [VTX_W-1:0]      cx;
		logic signed [VTX_W-1:0]      cy;
		logic signed [VDEPTH_W-1:0]   da;
		logic signed [VDEPTH_W-1:0]   db;
		logic signed [VDEPTH_W-1:0]   dc;
		logic [COLOR_W-1:0]           color;
		logic [CRD_W-1:0]             x0;
		logic [CRD_W-1:0]             x1;
		logic [CRD_W-1:0]             y0;
		logic [CRD_W-1:0]             y1;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

/* sv/trz_front.sv */
// Front part: frame registers, input stage, command decode and bounding box clipping.
module trz_front #(
	parameter int MAX_WIDTH  = trz_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = trz_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [trz_pkg::CMD_W-1:0]            cmd,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_a_x,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_a_y,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_b_x,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_b_y,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_c_x,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_c_y,
	input  logic signed [trz_pkg::VDEPTH_W-1:0]  vert_a_depth,
	input  logic signed [trz_pkg::VDEPTH_W-1:0]  vert_b_depth,
	input  logic signed [trz_pkg::VDEPTH_W-1:0]  vert_c_depth,
	input  logic [trz_pkg::COLOR_W-1:0]          fill_color,
	input  logic                                 cfg_we,
	input  logic [trz_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [trz_pkg::CFG_W-1:0]            cfg_wdata,
	input  logic                                 init_busy,
	input  trz_pkg::q_stat_t                     q_stat,
	output logic                                 q_push,
	output trz_pkg::job_t                        q_data
);
	import trz_pkg::*;

	logic [CFG_W-1:0]            frame_w_q, frame_h_q;
	logic                        s1_valid_q;
	logic [CMD_W-1:0]            cmd_s1;
	logic signed [VTX_W-1:0]     ax_s1, ay_s1, bx_s1, by_s1, cx_s1, cy_s1;
	logic signed [VDEPTH_W-1:0]  da_s1, db_s1, dc_s1;
	logic [COLOR_W-1:0]          color_s1;
	logic signed [13:0]          w_eff, h_eff;
	logic                        accept, in_frame;

	function automatic logic signed [13:0] min3(input logic signed [13:0] a,
		input logic signed [13:0] b, input logic signed [13:0] c);
		logic signed [13:0] m;
		m = (a < b) ? a : b;
		return (m < c) ? m : c;
	endfunction

	function automatic logic signed [13:0] max3(input logic signed [13:0] a,
		input logic signed [13:0] b, input logic signed [13:0] c);
		logic signed [13:0] m;
		m = (a > b) ? a : b;
		return (m > c) ? m : c;
	endfunction

	function automatic logic [CRD_W-1:0] clip(input logic signed [13:0] v,
		input logic signed [13:0] hi);
		logic signed [13:0] r;
		r = (v < 14'sd0) ? 14'sd0 : ((v > hi) ? hi : v);
		return r[CRD_W-1:0];
	endfunction

	assign in_stall = init_busy || (s1_valid_q && q_stat.full);
	assign accept   = in_valid && !in_stall;
	assign q_push   = s1_valid_q && !q_stat.full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_w_q  <= 9'd256;
			frame_h_q  <= 9'd256;
			s1_valid_q <= 1'b0;
		end else begin
			if (cfg_we && cfg_index == REG_FRAME_WIDTH) frame_w_q <= cfg_wdata;
			if (cfg_we && cfg_index == REG_FRAME_HEIGHT) frame_h_q <= cfg_wdata;
			if (accept) s1_valid_q <= 1'b1;
			else if (q_push) s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1   <= cmd;
			ax_s1    <= vert_a_x;
			ay_s1    <= vert_a_y;
			bx_s1    <= vert_b_x;
			by_s1    <= vert_b_y;
			cx_s1    <= vert_c_x;
			cy_s1    <= vert_c_y;
			da_s1    <= vert_a_depth;
			db_s1    <= vert_b_depth;
			dc_s1    <= vert_c_depth;
			color_s1 <= fill_color;
		end
	end

	// A zero register acts as one; a value above the maximum acts as the maximum.
	always_comb begin
		w_eff = (frame_w_q == '0) ? 14'sd1 : $signed(14'(frame_w_q));
		if (w_eff > $signed(14'(MAX_WIDTH))) w_eff = $signed(14'(MAX_WIDTH));
		h_eff = (frame_h_q == '0) ? 14'sd1 : $signed(14'(frame_h_q));
		if (h_eff > $signed(14'(MAX_HEIGHT))) h_eff = $signed(14'(MAX_HEIGHT));
	end

	assign in_frame = (ax_s1 >= 0) && (14'(ax_s1) < w_eff) &&
		(ay_s1 >= 0) && (14'(ay_s1) < h_eff);

	always_comb begin
		q_data.ax    = ax_s1;
		q_data.ay    = ay_s1;
		q_data.bx    = bx_s1;
		q_data.by    = by_s1;
		q_data.cx    = cx_s1;
		q_data.cy    = cy_s1;
		q_data.da    = da_s1;
		q_data.db    = db_s1;
		q_data.dc    = dc_s1;
		q_data.color = color_s1;
		q_data.x0    = clip(min3(14'(ax_s1), 14'(bx_s1), 14'(cx_s1)), w_eff - 14'sd1);
		q_data.x1    = clip(max3(14'(ax_s1), 14'(bx_s1), 14'(cx_s1)), w_eff - 14'sd1);
		q_data.y0    = clip(min3(14'(ay_s1), 14'(by_s1), 14'(cy_s1)), h_eff - 14'sd1);
		q_data.y1    = clip(max3(14'(ay_s1), 14'(by_s1), 14'(cy_s1)), h_eff - 14'sd1);
		case (cmd_s1)
			CMD_DRAW:  q_data.kind = JOB_DRAW;
			CMD_CLEAR: q_data.kind = JOB_CLEAR;
			CMD_READ:  q_data.kind = in_frame ? JOB_READ : JOB_NOP;
			default:   q_data.kind = JOB_NOP;
		endcase
	end

endmodule

/* sv/trz_queue.sv */
// Two-entry queue of decoded jobs between the front and the back.
module trz_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  trz_pkg::job_t     push_data,
	input  logic              pop,
	output trz_pkg::job_t     head,
	output trz_pkg::q_stat_t  stat
);
	import trz_pkg::*;

	job_t       entry_q [2];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] cnt_q;

	assign head       = entry_q[rd_ptr_q];
	assign stat.full  = (cnt_q == 2'd2);
	assign stat.empty = (cnt_q == 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			if (push && !pop) cnt_q <= cnt_q + 2'd1;
			else if (pop && !push) cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_data;
	end

endmodule

/* sv/trz_back.sv */
// Back part: store sweeps, pixel reads, and the triangle walk with depth test.
module trz_back #(
	parameter int MAX_WIDTH  = trz_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = trz_pkg::MAX_HEIGHT_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  trz_pkg::q_stat_t               q_stat,
	input  trz_pkg::job_t                  q_data,
	output logic                           q_pop,
	output logic                           init_busy,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [trz_pkg::COLOR_W-1:0]    pixel_color,
	output logic [trz_pkg::ZBUF_W-1:0]     pixel_depth,
	output logic [trz_pkg::COUNT_W-1:0]    pixels_written,
	output logic                           culled
);
	import trz_pkg::*;

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [3:0] ST_INIT  = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_CLR   = 4'd2;
	localparam logic [3:0] ST_RD    = 4'd3;
	localparam logic [3:0] ST_SETUP = 4'd4;
	localparam logic [3:0] ST_START = 4'd5;
	localparam logic [3:0] ST_PIX   = 4'd6;
	localparam logic [3:0] ST_MAC   = 4'd7;
	localparam logic [3:0] ST_TEST  = 4'd8;
	localparam logic [3:0] ST_DIV   = 4'd9;
	localparam logic [3:0] ST_CMP   = 4'd10;
	localparam logic [3:0] ST_WR    = 4'd11;
	localparam logic [3:0] ST_DONE  = 4'd12;

	logic [COLOR_W-1:0]       color_mem [DEPTH];
	logic [ZBUF_W-1:0]        depth_mem [DEPTH];
	logic [COLOR_W-1:0]       color_rd_q;
	logic [ZBUF_W-1:0]        depth_rd_q;

	logic [3:0]               state_q;
	logic [3:0]               step_q;
	logic [ADDR_W-1:0]        clr_q;
	logic                     out_valid_q;
	job_t                     job_q;
	logic signed [E_W-1:0]    tot_q, e0_q, e1_q, e2_q, er0_q, er1_q, er2_q;
	logic signed [PROD_W-1:0] prod_q;
	logic signed [S_W-1:0]    s_q;
	logic [S_W-1:0]           rem_q, div_q;
	logic [ZBUF_W-1:0]        zq_q;
	logic [CRD_W-1:0]         x_q, y_q;
	logic [COUNT_W-1:0]       count_q;
	logic                     cull_q;
	logic [COLOR_W-1:0]       rcolor_q, out_color_q;
	logic [ZBUF_W-1:0]        rdepth_q, out_depth_q;
	logic [COUNT_W-1:0]       out_count_q;
	logic                     out_cull_q;

	logic                     out_free, covered, last_x, last_y, do_adv;
	logic                     s_pos, s_sat, zpass, clr_last;
	logic [3:0]               walk_next;
	logic signed [E_W-1:0]    mul_a, mul_b;
	logic signed [E_W-1:0]    ax_e, ay_e, bx_e, by_e, cx_e, cy_e, x0_e, y0_e;
	logic signed [E_W-1:0]    dx0, dy0, dx1, dy1, dx2, dy2;
	logic signed [S_W-1:0]    sat_lim;
	logic [2:0]               acc_idx;
	logic signed [E_W-1:0]    acc_val;
	logic [ADDR_W-1:0]        pix_addr, rd_addr, mem_raddr, mem_waddr;
	logic                     mem_re, mem_we, wr_pix;

	assign q_pop     = (state_q == ST_IDLE) && !q_stat.empty;
	assign init_busy = (state_q == ST_INIT);
	assign out_free  = !out_valid_q || !out_stall;
	assign clr_last  = (clr_q == ADDR_W'(DEPTH - 1));

	assign pix_addr = ADDR_W'(y_q) * ADDR_W'(MAX_WIDTH) + ADDR_W'(x_q);
	assign rd_addr  = ADDR_W'(q_data.ay[CRD_W-1:0]) * ADDR_W'(MAX_WIDTH) +
		ADDR_W'(q_data.ax[CRD_W-1:0]);

	assign ax_e = E_W'(job_q.ax);
	assign ay_e = E_W'(job_q.ay);
	assign bx_e = E_W'(job_q.bx);
	assign by_e = E_W'(job_q.by);
	assign cx_e = E_W'(job_q.cx);
	assign cy_e = E_W'(job_q.cy);
	assign x0_e = $signed(E_W'(job_q.x0));
	assign y0_e = $signed(E_W'(job_q.y0));

	// Edge area increments per step in column and in row.
	assign dx0 = by_e - cy_e;
	assign dy0 = cx_e - bx_e;
	assign dx1 = cy_e - ay_e;
	assign dy1 = ax_e - cx_e;
	assign dx2 = ay_e - by_e;
	assign dy2 = bx_e - ax_e;

	assign covered = !e0_q[E_W-1] && !e1_q[E_W-1] && !e2_q[E_W-1];
	assign last_x  = (x_q == job_q.x1);
	assign last_y  = (y_q == job_q.y1);
	assign sat_lim = S_W'(tot_q) <<< 16;
	assign s_pos   = (s_q > 0);
	assign s_sat   = (s_q >= sat_lim);
	assign zpass   = (zq_q > depth_rd_q) || ((zq_q == depth_rd_q) && (rem_q != '0));

	assign do_adv = ((state_q == ST_PIX) && !covered) ||
		((state_q == ST_TEST) && !s_pos) ||
		((state_q == ST_CMP) && !zpass) ||
		(state_q == ST_WR);
	assign walk_next = (last_x && last_y) ? ST_DONE : ST_PIX;

	// Shared multiplier: edge setup products, then the per-pixel depth sum.
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		if (state_q == ST_SETUP) begin
			case (step_q)
				4'd0: begin mul_a = bx_e - ax_e; mul_b = cy_e - ay_e; end
				4'd1: begin mul_a = cx_e - ax_e; mul_b = by_e - ay_e; end
				4'd2: begin mul_a = bx_e - x0_e; mul_b = cy_e - y0_e; end
				4'd3: begin mul_a = cx_e - x0_e; mul_b = by_e - y0_e; end
				4'd4: begin mul_a = cx_e - x0_e; mul_b = ay_e - y0_e; end
				4'd5: begin mul_a = ax_e - x0_e; mul_b = cy_e - y0_e; end
				4'd6: begin mul_a = ax_e - x0_e; mul_b = by_e - y0_e; end
				4'd7: begin mul_a = bx_e - x0_e; mul_b = ay_e - y0_e; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end else begin
			case (step_q)
				4'd0: begin mul_a = E_W'(job_q.da); mul_b = e0_q; end
				4'd1: begin mul_a = E_W'(job_q.db); mul_b = e1_q; end
				4'd2: begin mul_a = E_W'(job_q.dc); mul_b = e2_q; end
				default: begin mul_a = '0; mul_b = '0; end
			endcase
		end
	end

	assign acc_idx = 3'(step_q - 4'd1);
	assign acc_val = acc_idx[0] ? -E_W'(prod_q) : E_W'(prod_q);

	// Store port control.
	assign wr_pix    = (state_q == ST_WR);
	assign mem_we    = (state_q == ST_INIT) || (state_q == ST_CLR) || wr_pix;
	assign mem_waddr = wr_pix ? pix_addr : clr_q;
	assign mem_re    = (q_pop && q_data.kind == JOB_READ) || ((state_q == ST_PIX) && covered);
	assign mem_raddr = (state_q == ST_IDLE) ? rd_addr : pix_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			color_mem[mem_waddr] <= wr_pix ? job_q.color : '0;
			depth_mem[mem_waddr] <= wr_pix ? zq_q : '0;
		end
		if (mem_re) begin
			color_rd_q <= color_mem[mem_raddr];
			depth_rd_q <= depth_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			step_q      <= '0;
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_INIT: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (q_pop) begin
						step_q <= '0;
						clr_q  <= '0;
						case (q_data.kind)
							JOB_DRAW:  state_q <= ST_SETUP;
							JOB_CLEAR: state_q <= ST_CLR;
							JOB_READ:  state_q <= ST_RD;
							default:   state_q <= ST_DONE;
						endcase
					end
				end
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_last) state_q <= ST_DONE;
				end
				ST_RD: state_q <= ST_DONE;
				ST_SETUP: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd8) state_q <= ST_START;
				end
				ST_START: state_q <= (tot_q < 2) ? ST_DONE : ST_PIX;
				ST_PIX: begin
					step_q <= '0;
					if (covered) state_q <= ST_MAC;
					else state_q <= walk_next;
				end
				ST_MAC: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd3) state_q <= ST_TEST;
				end
				ST_TEST: begin
					step_q <= '0;
					if (!s_pos) state_q <= walk_next;
					else if (s_sat) state_q <= ST_WR;
					else state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q + 4'd1;
					if (step_q == 4'd7) state_q <= ST_CMP;
				end
				ST_CMP: state_q <= zpass ? ST_WR : walk_next;
				ST_WR: state_q <= walk_next;
				ST_DONE: if (out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (q_pop) begin
			job_q    <= q_data;
			count_q  <= '0;
			cull_q   <= 1'b0;
			rcolor_q <= '0;
			rdepth_q <= '0;
			tot_q    <= '0;
			e0_q     <= '0;
			e1_q     <= '0;
			e2_q     <= '0;
		end
		if (state_q == ST_SETUP && step_q != 4'd0) begin
			case (acc_idx[2:1])
				2'd0:    tot_q <= tot_q + acc_val;
				2'd1:    e0_q  <= e0_q + acc_val;
				2'd2:    e1_q  <= e1_q + acc_val;
				default: e2_q  <= e2_q + acc_val;
			endcase
		end
		if (state_q == ST_START) begin
			er0_q  <= e0_q;
			er1_q  <= e1_q;
			er2_q  <= e2_q;
			x_q    <= job_q.x0;
			y_q    <= job_q.y0;
			cull_q <= (tot_q < 2);
		end
		if (state_q == ST_PIX) s_q <= '0;
		if (state_q == ST_MAC && step_q != 4'd0) s_q <= s_q + S_W'(prod_q);
		if (state_q == ST_TEST) begin
			zq_q  <= s_sat ? 8'hFF : 8'h00;
			rem_q <= S_W'(s_q);
			div_q <= S_W'(tot_q) << 15;
		end
		// Restoring division: one quotient bit per cycle, eight bits in all.
		if (state_q == ST_DIV) begin
			if (rem_q >= div_q) begin
				rem_q <= rem_q - div_q;
				zq_q  <= {zq_q[ZBUF_W-2:0], 1'b1};
			end else begin
				zq_q  <= {zq_q[ZBUF_W-2:0], 1'b0};
			end
			div_q <= div_q >> 1;
		end
		if (state_q == ST_RD) begin
			rcolor_q <= color_rd_q;
			rdepth_q <= depth_rd_q;
		end
		if (wr_pix) count_q <= count_q + 1'b1;
		if (do_adv && !(last_x && last_y)) begin
			if (last_x) begin
				x_q   <= job_q.x0;
				y_q   <= y_q + 1'b1;
				er0_q <= er0_q + dy0;
				er1_q <= er1_q + dy1;
				er2_q <= er2_q + dy2;
				e0_q  <= er0_q + dy0;
				e1_q  <= er1_q + dy1;
				e2_q  <= er2_q + dy2;
			end else begin
				x_q  <= x_q + 1'b1;
				e0_q <= e0_q + dx0;
				e1_q <= e1_q + dx1;
				e2_q <= e2_q + dx2;
			end
		end
		if (state_q == ST_DONE && out_free) begin
			out_color_q <= rcolor_q;
			out_depth_q <= rdepth_q;
			out_count_q <= count_q;
			out_cull_q  <= cull_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign pixel_color    = out_color_q;
	assign pixel_depth    = out_depth_q;
	assign pixels_written = out_count_q;
	assign culled         = out_cull_q;

endmodule

/* sv/triangle_raster_zbuffer_core.sv */
// Top level of the triangle rasterizer with color and depth stores.
// Each item carries one command. A draw takes three integer vertices with depths in
// 1/256 units and one color; it is culled when the doubled signed area is below two,
// otherwise the bounding box, clipped to the active frame, is walked one pixel at a
// time. A covered pixel forms the depth sum on the shared multiplier, is tested and,
// unless that settles it, goes through the bit-serial divide and the depth compare,
// and is written if it passes. A clear sweeps all MAX_WIDTH * MAX_HEIGHT entries of
// both stores one entry per cycle, and the same sweep runs after reset, during which
// in_stall is held high (configuration writes are still taken). A read returns zero
// outside the active frame. Each item gives one result; the output register lets the
// next item start while a result waits to be taken, and a two-entry queue lets the
// input side take items while a draw is running.
module triangle_raster_zbuffer_core #(
	parameter int MAX_WIDTH  = trz_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = trz_pkg::MAX_HEIGHT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic [trz_pkg::CMD_W-1:0]            cmd,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_a_x,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_a_y,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_b_x,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_b_y,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_c_x,
	input  logic signed [trz_pkg::VTX_W-1:0]     vert_c_y,
	input  logic signed [trz_pkg::VDEPTH_W-1:0]  vert_a_depth,
	input  logic signed [trz_pkg::VDEPTH_W-1:0]  vert_b_depth,
	input  logic signed [trz_pkg::VDEPTH_W-1:0]  vert_c_depth,
	input  logic [trz_pkg::COLOR_W-1:0]          fill_color,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [trz_pkg::COLOR_W-1:0]          pixel_color,
	output logic [trz_pkg::ZBUF_W-1:0]           pixel_depth,
	output logic [trz_pkg::COUNT_W-1:0]          pixels_written,
	output logic                                 culled,
	input  logic                                 cfg_we,
	input  logic [trz_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [trz_pkg::CFG_W-1:0]            cfg_wdata
);
	import trz_pkg::*;

	logic    q_push, q_pop, init_busy;
	job_t    q_in, q_head;
	q_stat_t q_stat;

	// The front decodes commands and clips the box against the frame registers.
	trz_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_front (
		.clk, .arst_n, .in_valid, .in_stall, .cmd,
		.vert_a_x, .vert_a_y, .vert_b_x, .vert_b_y, .vert_c_x, .vert_c_y,
		.vert_a_depth, .vert_b_depth, .vert_c_depth, .fill_color,
		.cfg_we, .cfg_index, .cfg_wdata, .init_busy,
		.q_stat, .q_push, .q_data(q_in)
	);

	trz_queue u_queue (
		.clk, .arst_n, .push(q_push), .push_data(q_in), .pop(q_pop),
		.head(q_head), .stat(q_stat)
	);

	// The back owns both stores and does all per-pixel work.
	trz_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_back (
		.clk, .arst_n, .q_stat, .q_data(q_head), .q_pop, .init_busy,
		.out_valid, .out_stall, .pixel_color, .pixel_depth, .pixels_written, .culled
	);

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("job pushed into a full queue");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("job popped from an empty queue");

	a_cull_no_pixels: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && culled) |-> (pixels_written == '0))
		else $error("culled draw reports written pixels");

	a_init_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		init_busy |-> !out_valid)
		else $error("result shown during the store sweep after reset");

endmodule
